// ===== src/fsgs_pkg.sv =====
// Package for the flow sticky gateway selector.
// Holds sizes, codes, table entry types and the sequencer states.
// No dependencies.
package fsgs_pkg;

	localparam int MAX_GATES  = 8;
	localparam int FLOW_DEPTH = 64;

	localparam int GATE_IDX_W = $clog2(MAX_GATES);
	localparam int GATE_CNT_W = $clog2(MAX_GATES + 1);
	localparam int FLOW_IDX_W = $clog2(FLOW_DEPTH);
	localparam int FLOW_CNT_W = $clog2(FLOW_DEPTH + 1);

	localparam int MAC_W   = 48;
	localparam int IP_W    = 32;
	localparam int SPEED_W = 16;
	localparam int TIME_W  = 32;
	localparam int PORT_W  = 16;
	localparam int LIMIT_W = 16;
	localparam int CFG_IDX_W = 8;

	localparam logic [LIMIT_W-1:0] STALE_RESET = 16'd20;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 8'd1;

	localparam logic [1:0] MODE_DATA  = 2'd0;
	localparam logic [1:0] MODE_PONG  = 2'd1;
	localparam logic [1:0] MODE_ANTI  = 2'd2;
	localparam logic [1:0] MODE_SWEEP = 2'd3;

	typedef enum logic [3:0] {
		ST_CACHED  = 4'd0,
		ST_NEW     = 4'd1,
		ST_DROP    = 4'd2,
		ST_REFRESH = 4'd3,
		ST_ADDED   = 4'd4,
		ST_FULL    = 4'd5,
		ST_REMOVED = 4'd6,
		ST_UNKNOWN = 4'd7,
		ST_SWEPT   = 4'd8,
		ST_IGNORED = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOD,
		S_PURGE,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [MAC_W-1:0]   mac;
		logic [IP_W-1:0]    ip;
		logic [SPEED_W-1:0] speed;
		logic [TIME_W-1:0]  seen;
	} gate_t;

	typedef struct packed {
		logic [PORT_W-1:0]     port;
		logic [GATE_IDX_W-1:0] gate;
		logic [TIME_W-1:0]     seen;
	} flow_t;

	localparam int FLOW_W = $bits(flow_t);

endpackage

// ===== src/flow_sticky_gateway_selector_top.sv =====
// Top level of the flow sticky gateway selector: gateway table, sequencer and flow cache.
// Depends on fsgs_pkg, fsgs_ram and fsgs_mod.
//
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    mode header_ok now_seconds peer_* flow_port
// out      output     out_valid/out_stall  status dest_mac frame_src_mac gate_index gate_count
// cfg      input      cfg_valid/cfg_ready  cfg_index cfg_data
//
// A pong, a data or antipong item without its header, or an unknown antipong goes
// straight to the finish step. A data item scans the flow cache one entry a cycle
// until a hit; a miss then runs the remainder unit unless the gateway table is empty.
// Antipong and sweep items pass once over the flow cache RAM. Reset clears the gateway
// and flow counts.
// A stalled result holds the finish step; the next item is taken once it is loaded.
module flow_sticky_gateway_selector_top import fsgs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic                  header_ok,
	input  logic [TIME_W-1:0]     now_seconds,
	input  logic [MAC_W-1:0]      peer_mac,
	input  logic [IP_W-1:0]       peer_ip,
	input  logic [SPEED_W-1:0]    peer_speed,
	input  logic [PORT_W-1:0]     flow_port,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            status,
	output logic [MAC_W-1:0]      dest_mac,
	output logic [MAC_W-1:0]      frame_src_mac,
	output logic [GATE_IDX_W-1:0] gate_index,
	output logic [GATE_CNT_W-1:0] gate_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [MAC_W-1:0]      cfg_data
);

	state_t                state_q, state_d;
	logic                  in_acc;
	logic [TIME_W-1:0]     now_q;
	logic [PORT_W-1:0]     port_q;
	logic [GATE_CNT_W-1:0] gates_q, gates_d;
	logic [FLOW_CNT_W-1:0] flows_q, rd_q, wr_q;
	logic                  vld_s1;
	logic [GATE_IDX_W-1:0] del_q;
	logic                  sweep_q;
	logic [MAX_GATES-1:0]  gone_q, gone_d;
	logic [GATE_IDX_W-1:0] remap_q [MAX_GATES];
	logic [GATE_IDX_W-1:0] remap_d [MAX_GATES];
	logic [GATE_CNT_W-1:0] old_q;
	status_t               res_status_q, res_status_d;
	logic [GATE_IDX_W-1:0] res_idx_q, res_idx_d;
	logic [MAC_W-1:0]      own_mac_q;
	logic [LIMIT_W-1:0]    stale_q;
	gate_t                 gate_q [MAX_GATES];
	gate_t                 gate_d [MAX_GATES];
	logic                  out_valid_q;
	logic                  out_load;

	logic                  fhit;
	logic [GATE_IDX_W-1:0] fpos;

	logic                  issue;
	logic                  scan_end;
	logic                  hit_now;
	flow_t                 rd_flow;
	logic [FLOW_W-1:0]     ram_rdata;
	logic                  ram_we;
	logic [FLOW_IDX_W-1:0] ram_waddr;
	flow_t                 ram_wdata;
	logic                  keep;
	logic [GATE_IDX_W-1:0] gate_renum;
	logic                  mod_start, mod_done;
	logic [GATE_IDX_W-1:0] mod_rem;
	logic                  cache_room;
	logic [TIME_W-1:0]     age;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign rd_flow   = flow_t'(ram_rdata);
	assign issue     = (rd_q < flows_q);
	assign scan_end  = !vld_s1 && !issue;
	assign hit_now   = vld_s1 && (rd_flow.port == port_q);
	assign mod_start = (state_q == S_SCAN) && !hit_now && scan_end && (gates_q != '0);
	assign cache_room = (flows_q < FLOW_CNT_W'(FLOW_DEPTH));
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign age       = now_q - rd_flow.seen;

	always_comb begin
		fhit = 1'b0;
		fpos = '0;
		for (int i = MAX_GATES - 1; i >= 0; i--) begin
			if ((GATE_CNT_W'(i) < gates_q) && (gate_q[i].mac == peer_mac)) begin
				fhit = 1'b1;
				fpos = GATE_IDX_W'(i);
			end
		end
	end

	always_comb begin
		if (sweep_q) begin
			keep = !(age > {{(TIME_W-LIMIT_W){1'b0}}, stale_q})
				&& ({1'b0, rd_flow.gate} < old_q) && !gone_q[rd_flow.gate];
			gate_renum = remap_q[rd_flow.gate];
		end else begin
			keep = (rd_flow.gate != del_q);
			gate_renum = (rd_flow.gate > del_q) ? rd_flow.gate - GATE_IDX_W'(1) : rd_flow.gate;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (mode)
						MODE_DATA:  state_d = header_ok ? S_SCAN : S_FIN;
						MODE_ANTI:  state_d = (header_ok && fhit) ? S_PURGE : S_FIN;
						MODE_SWEEP: state_d = S_PURGE;
						default:    state_d = S_FIN;
					endcase
				end
			end
			S_SCAN: begin
				if (hit_now) begin
					state_d = S_FIN;
				end else if (scan_end) begin
					state_d = (gates_q != '0) ? S_MOD : S_FIN;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					state_d = S_FIN;
				end
			end
			S_PURGE: begin
				if (scan_end) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		logic [GATE_CNT_W-1:0] cnt;
		logic                  stale_g;
		gate_d       = gate_q;
		gates_d      = gates_q;
		gone_d       = gone_q;
		remap_d      = remap_q;
		res_status_d = res_status_q;
		res_idx_d    = res_idx_q;
		cnt          = '0;
		stale_g      = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = wr_q[FLOW_IDX_W-1:0];
		ram_wdata    = '{port: rd_flow.port, gate: gate_renum, seen: rd_flow.seen};
		if (state_q == S_IDLE && in_acc) begin
			res_idx_d = '0;
			case (mode)
				MODE_DATA: begin
					res_status_d = ST_DROP;
				end
				MODE_PONG: begin
					if (!header_ok) begin
						res_status_d = ST_IGNORED;
					end else if (fhit) begin
						if (gate_q[fpos].ip != peer_ip) begin
							gate_d[fpos].ip    = peer_ip;
							gate_d[fpos].speed = peer_speed;
						end
						gate_d[fpos].seen = now_seconds;
						res_status_d = ST_REFRESH;
						res_idx_d    = fpos;
					end else if (gates_q >= GATE_CNT_W'(MAX_GATES)) begin
						res_status_d = ST_FULL;
					end else begin
						gate_d[gates_q[GATE_IDX_W-1:0]] = '{mac: peer_mac, ip: peer_ip,
							speed: peer_speed, seen: now_seconds};
						gates_d      = gates_q + GATE_CNT_W'(1);
						res_status_d = ST_ADDED;
						res_idx_d    = gates_q[GATE_IDX_W-1:0];
					end
				end
				MODE_ANTI: begin
					if (!header_ok) begin
						res_status_d = ST_IGNORED;
					end else if (!fhit) begin
						res_status_d = ST_UNKNOWN;
					end else begin
						for (int i = 0; i < MAX_GATES - 1; i++) begin
							if (GATE_IDX_W'(i) >= fpos) begin
								gate_d[i] = gate_q[i+1];
							end
						end
						gates_d      = gates_q - GATE_CNT_W'(1);
						res_status_d = ST_REMOVED;
						res_idx_d    = fpos;
					end
				end
				default: begin
					for (int i = 0; i < MAX_GATES; i++) begin
						stale_g = (now_seconds - gate_q[i].seen)
							> {{(TIME_W-LIMIT_W){1'b0}}, stale_q};
						gone_d[i]  = stale_g;
						remap_d[i] = cnt[GATE_IDX_W-1:0];
						if ((GATE_CNT_W'(i) < gates_q) && !stale_g) begin
							gate_d[cnt[GATE_IDX_W-1:0]] = gate_q[i];
							cnt = cnt + GATE_CNT_W'(1);
						end
					end
					gates_d      = cnt;
					res_status_d = ST_SWEPT;
				end
			endcase
		end else if (state_q == S_SCAN && hit_now) begin
			if ({1'b0, rd_flow.gate} < gates_q) begin
				res_status_d = ST_CACHED;
				res_idx_d    = rd_flow.gate;
			end
		end else if (state_q == S_MOD && mod_done) begin
			res_status_d = ST_NEW;
			res_idx_d    = mod_rem;
			if (cache_room) begin
				ram_we    = 1'b1;
				ram_waddr = flows_q[FLOW_IDX_W-1:0];
				ram_wdata = '{port: port_q, gate: mod_rem, seen: now_q};
			end
		end else if (state_q == S_PURGE && vld_s1 && keep) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gates_q     <= '0;
			flows_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			own_mac_q   <= '0;
			stale_q     <= STALE_RESET;
		end else begin
			state_q <= state_d;
			gates_q <= gates_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_OWN_MAC) begin
					own_mac_q <= cfg_data;
				end else if (cfg_index == REG_STALE_LIMIT) begin
					stale_q <= cfg_data[LIMIT_W-1:0];
				end
			end
			if (state_q == S_IDLE) begin
				rd_q   <= '0;
				wr_q   <= '0;
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					rd_q <= rd_q + FLOW_CNT_W'(1);
				end
				if (state_q == S_PURGE && vld_s1 && keep) begin
					wr_q <= wr_q + FLOW_CNT_W'(1);
				end
			end
			if (state_q == S_PURGE && scan_end) begin
				flows_q <= wr_q;
			end
			if (state_q == S_MOD && mod_done && cache_room) begin
				flows_q <= flows_q + FLOW_CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		gate_q       <= gate_d;
		gone_q       <= gone_d;
		remap_q      <= remap_d;
		res_status_q <= res_status_d;
		res_idx_q    <= res_idx_d;
		if (in_acc) begin
			now_q   <= now_seconds;
			port_q  <= flow_port;
			del_q   <= fpos;
			sweep_q <= (mode == MODE_SWEEP);
			old_q   <= gates_q;
		end
		if (out_load) begin
			status     <= res_status_q;
			gate_index <= res_idx_q;
			gate_count <= gates_q;
			if (res_status_q == ST_CACHED || res_status_q == ST_NEW) begin
				dest_mac      <= gate_q[res_idx_q].mac;
				frame_src_mac <= own_mac_q;
			end else begin
				dest_mac      <= '0;
				frame_src_mac <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	fsgs_ram #(
		.WIDTH(FLOW_W),
		.DEPTH(FLOW_DEPTH)
	) u_flow_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_q[FLOW_IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	fsgs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (port_q),
		.divisor  (gates_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

endmodule

// ===== src/fsgs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fsgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/fsgs_mod.sv =====
// Restoring remainder unit: port number modulo gateway count, one bit a cycle.
// Depends on fsgs_pkg.
module fsgs_mod import fsgs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PORT_W-1:0]     dividend,
	input  logic [GATE_CNT_W-1:0] divisor,
	output logic                  done,
	output logic [GATE_IDX_W-1:0] rem
);

	localparam int CNT_W = $clog2(PORT_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PORT_W-1:0]     dq_q;
	logic [GATE_CNT_W-1:0] rem_q;
	logic [GATE_CNT_W-1:0] d_q;
	logic [GATE_CNT_W:0]   trial;
	logic [GATE_CNT_W:0]   diff;

	assign trial = {rem_q, dq_q[PORT_W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PORT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			dq_q <= {dq_q[PORT_W-2:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				rem_q <= diff[GATE_CNT_W-1:0];
			end else begin
				rem_q <= trial[GATE_CNT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q[GATE_IDX_W-1:0];

endmodule

// ===== src/fsgs_checker.sv =====
// Port level checks for the flow sticky gateway selector, bound to its top level.
// Depends on fsgs_pkg and flow_sticky_gateway_selector_top.
module fsgs_checker import fsgs_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [3:0]            status,
	input logic [MAC_W-1:0]      dest_mac,
	input logic [MAC_W-1:0]      frame_src_mac,
	input logic [GATE_IDX_W-1:0] gate_index,
	input logic [GATE_CNT_W-1:0] gate_count
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(dest_mac))
		else $error("Stalled result changed.");

	a_nofwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_CACHED && status != ST_NEW
		|-> dest_mac == '0 && frame_src_mac == '0)
		else $error("MAC fields set on a result that does not forward.");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gate_count <= GATE_CNT_W'(MAX_GATES))
		else $error("Gateway count above table size.");

	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ADDED |-> {1'b0, gate_index} + GATE_CNT_W'(1) == gate_count)
		else $error("Added gateway is not the last table entry.");

	a_fwd_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_CACHED || status == ST_NEW)
		|-> {1'b0, gate_index} < gate_count)
		else $error("Forward position outside the gateway table.");

endmodule

bind flow_sticky_gateway_selector_top fsgs_checker u_fsgs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.dest_mac      (dest_mac),
	.frame_src_mac (frame_src_mac),
	.gate_index    (gate_index),
	.gate_count    (gate_count)
);
